// ===== hdl/bbfp_pkg.sv =====
// ============================================================================
// Bit and byte field packer package
// Shared types and constants: request kinds, sequencer states, result record.
// ============================================================================
package bbfp_pkg;

    // Request kinds carried on the kind field.
    localparam logic [1:0] KIND_ADD_BITS  = 2'd0;
    localparam logic [1:0] KIND_ADD_BYTES = 2'd1;
    localparam logic [1:0] KIND_READ      = 2'd2;

    // Largest number of bits or bytes one request may carry.
    localparam logic [3:0] MAX_COUNT = 4'd8;

    // Reset value of the stream size register.
    localparam logic [6:0] LIMIT_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_BITS_RD,
        ST_BITS_WR,
        ST_BYTES,
        ST_READ_WAIT,
        ST_DONE
    } seq_state_t;

    // One finished result as handed from the sequencer to the output stage.
    typedef struct packed {
        logic       ok;
        logic [7:0] data;
    } result_t;

endpackage

// ===== hdl/bbfp_mem.sv =====
// ============================================================================
// Buffer memory
// Byte-wide simple dual-port RAM, one write and one registered read a cycle.
// ============================================================================
module bbfp_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/bbfp_seq.sv =====
// ============================================================================
// Packer sequencer
// Decodes a request, runs its reads, writes and read-modify-write steps on
// the buffer memory and keeps the byte and bit fill position.
// ============================================================================
module bbfp_seq #(
    parameter int AW           = 6,
    parameter int PW           = 7,
    parameter int LW           = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    // request side
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          kind,
    input  logic [63:0]         value,
    input  logic [3:0]          count,
    input  logic                little_endian,
    input  logic [5:0]          read_index,
    // stream size in force
    input  logic [LW-1:0]       limit,
    // result side
    output logic                res_valid,
    input  logic                res_ready,
    output bbfp_pkg::result_t   res,
    // buffer memory
    output logic                mem_wr_en,
    output logic [AW-1:0]       mem_wr_addr,
    output logic [7:0]          mem_wr_data,
    output logic                mem_rd_en,
    output logic [AW-1:0]       mem_rd_addr,
    input  logic [7:0]          mem_rd_data
);
    import bbfp_pkg::*;

    seq_state_t    state_reg, state_next;
    logic [1:0]    kind_reg;
    logic [63:0]   value_reg;
    logic [3:0]    count_reg;
    logic          le_reg;
    logic [5:0]    idx_reg;
    logic [3:0]    rem_reg, rem_next;
    logic [7:0]    bits_reg, bits_next;
    logic [2:0]    bidx_reg, bidx_next;
    logic [PW-1:0] byte_pos_reg, byte_pos_next;
    logic [2:0]    bit_pos_reg, bit_pos_next;
    logic          res_ok_reg, res_ok_next;
    logic [7:0]    res_data_reg, res_data_next;

    logic [LW-1:0] pos_l;
    logic [LW-1:0] cnt_l;
    logic [LW-1:0] idx_l;
    logic [LW-1:0] room_l;
    logic [3:0]    avail;
    logic [3:0]    take;
    logic [8:0]    mask_wide;
    logic [15:0]   ins_wide;
    logic [7:0]    old_byte;
    logic [7:0]    merged;
    logic [3:0]    bit_sum;
    logic          lsb_first;
    logic [2:0]    last_idx;
    logic [2:0]    sel_idx;
    logic [7:0]    sel_byte;
    logic          idx_written;

    // Position and item arithmetic shared by both combinational blocks.
    always_comb
    begin
        pos_l     = LW'(byte_pos_reg);
        cnt_l     = LW'(count_reg);
        idx_l     = LW'(idx_reg);
        room_l    = limit - pos_l;
        avail     = 4'd8 - {1'b0, bit_pos_reg};
        take      = (rem_reg < avail) ? rem_reg : avail;
        mask_wide = (9'd1 << take) - 9'd1;
        ins_wide  = {8'h00, bits_reg & mask_wide[7:0]} << bit_pos_reg;
        // A byte at the fill position holds data only once a bit went into it.
        old_byte  = (bit_pos_reg != 3'd0) ? mem_rd_data : 8'h00;
        merged    = old_byte | ins_wide[7:0];
        bit_sum   = {1'b0, bit_pos_reg} + take;
        lsb_first = le_reg && (count_reg == 4'd1 || count_reg == 4'd2 ||
                               count_reg == 4'd4 || count_reg == 4'd8);
        last_idx  = count_reg[2:0] - 3'd1;
        sel_idx   = lsb_first ? bidx_reg : (last_idx - bidx_reg);
        sel_byte  = value_reg[{sel_idx, 3'b000} +: 8];
        // Bytes beyond the fill position were never written and read as zero.
        idx_written = (idx_l < pos_l) || ((idx_l == pos_l) && (bit_pos_reg != 3'd0));
    end

    // Next state and the working registers.
    always_comb
    begin
        state_next    = state_reg;
        rem_next      = rem_reg;
        bits_next     = bits_reg;
        bidx_next     = bidx_reg;
        byte_pos_next = byte_pos_reg;
        bit_pos_next  = bit_pos_reg;
        res_ok_next   = res_ok_reg;
        res_data_next = res_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                    rem_next   = count;
                    bits_next  = value[7:0];
                    bidx_next  = 3'd0;
                end
            end
            ST_DECODE:
            begin
                res_data_next = 8'h00;
                res_ok_next   = 1'b0;
                state_next    = ST_DONE;
                case (kind_reg)
                    KIND_ADD_BITS:
                    begin
                        if (count_reg == 4'd0)
                        begin
                            res_ok_next = 1'b1;
                        end
                        else if (count_reg <= MAX_COUNT)
                        begin
                            state_next = ST_BITS_RD;
                        end
                    end
                    KIND_ADD_BYTES:
                    begin
                        if (count_reg == 4'd0)
                        begin
                            res_ok_next = 1'b1;
                        end
                        else if (count_reg <= MAX_COUNT && pos_l < limit &&
                                 bit_pos_reg == 3'd0 && cnt_l <= room_l)
                        begin
                            state_next = ST_BYTES;
                        end
                    end
                    KIND_READ:
                    begin
                        if (idx_l < limit)
                        begin
                            state_next = ST_READ_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_BITS_RD:
            begin
                // Running out of room ends the field; bits written so far stay.
                if (pos_l < limit)
                begin
                    state_next = ST_BITS_WR;
                end
                else
                begin
                    res_ok_next = 1'b0;
                    state_next  = ST_DONE;
                end
            end
            ST_BITS_WR:
            begin
                rem_next  = rem_reg - take;
                bits_next = bits_reg >> take;
                bit_pos_next = bit_sum[2:0];
                if (bit_sum[3])
                begin
                    byte_pos_next = byte_pos_reg + PW'(1);
                end
                if (rem_reg == take)
                begin
                    res_ok_next = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_BITS_RD;
                end
            end
            ST_BYTES:
            begin
                byte_pos_next = byte_pos_reg + PW'(1);
                bidx_next     = bidx_reg + 3'd1;
                if (bidx_reg == last_idx)
                begin
                    res_ok_next = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_READ_WAIT:
            begin
                res_ok_next   = 1'b1;
                res_data_next = idx_written ? mem_rd_data : 8'h00;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and memory port outputs.
    always_comb
    begin
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = byte_pos_reg[AW-1:0];
        mem_wr_data = merged;
        mem_rd_en   = 1'b0;
        mem_rd_addr = byte_pos_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_DECODE:
            begin
                if (kind_reg == KIND_READ)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(idx_reg);
                end
            end
            ST_BITS_RD:
            begin
                mem_rd_en = (pos_l < limit);
            end
            ST_BITS_WR:
            begin
                mem_wr_en = 1'b1;
            end
            ST_BYTES:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = sel_byte;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign res.ok   = res_ok_reg;
    assign res.data = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            byte_pos_reg <= '0;
            bit_pos_reg  <= 3'd0;
        end
        else
        begin
            state_reg    <= state_next;
            byte_pos_reg <= byte_pos_next;
            bit_pos_reg  <= bit_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            kind_reg  <= kind;
            value_reg <= value;
            count_reg <= count;
            le_reg    <= little_endian;
            idx_reg   <= read_index;
        end
        rem_reg      <= rem_next;
        bits_reg     <= bits_next;
        bidx_reg     <= bidx_next;
        res_ok_reg   <= res_ok_next;
        res_data_reg <= res_data_next;
    end

endmodule

// ===== hdl/bbfp_ostage.sv =====
// ============================================================================
// Output stage
// Result register that frees the sequencer while a result waits downstream.
// ============================================================================
module bbfp_ostage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    output logic              res_ready,
    input  bbfp_pkg::result_t res,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              ok,
    output logic [7:0]        read_data
);
    import bbfp_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    logic    load;

    assign res_ready = !out_valid_reg || out_ready;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = out_res_reg.ok;
    assign read_data = out_res_reg.data;

endmodule

// ===== hdl/bit_and_byte_field_packer.sv =====
// ============================================================================
// Bit and byte field packer
// Packs bit fields LSB first and byte fields in either order into a byte
// buffer, and reads single buffer bytes back.
// ============================================================================
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ------------------------------------------
//  in        in_valid / in_ready    kind, value, count, little_endian,
//                                   read_index
//  out       out_valid / out_ready  ok, read_data
//  cfg       cfg_valid / cfg_ready  cfg_data (stream size in bytes)
//
//  One request is worked on at a time. A request is decoded first; one that
//  is refused at decode or has a zero count goes straight to its result, a
//  read waits for the buffer byte, an add-bytes request writes its bytes one
//  by one, and an add-bits request reads and writes each buffer byte it
//  touches, ending early when it runs out of room. The next request is
//  accepted once the result has left the sequencer. The buffer memory has a
//  single port pair with a registered read, so every partial byte is read,
//  merged and written back, and every whole byte is only written. Reset
//  clears the fill position at once; there is no clearing pass. Bytes
//  at or beyond the fill position read as zero until they are written.
//  A result waiting in the output register does not block the next request;
//  only a second finished result waits for the output to be taken.
//
module bit_and_byte_field_packer #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [63:0] value,
    input  logic [3:0]  count,
    input  logic        little_endian,
    input  logic [5:0]  read_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ok,
    output logic [7:0]  read_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);
    import bbfp_pkg::*;

    // Address width of the buffer, width of the fill position (which can
    // reach BUFFER_BYTES itself) and the width used for limit compares.
    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int PW = $clog2(BUFFER_BYTES + 1);
    localparam int LW = (PW > 7) ? PW : 7;

    logic [6:0]    limit_reg;
    logic [LW-1:0] limit_eff;

    result_t       res;
    logic          res_valid;
    logic          res_ready;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [7:0]    mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [7:0]    mem_rd_data;

    // The stream size register is always ready; the user must write it only while
    // the packer is idle, as the block itself does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    // A stream size above the buffer is clamped to the buffer.
    assign limit_eff = (LW'(limit_reg) > LW'(BUFFER_BYTES)) ? LW'(BUFFER_BYTES)
                                                            : LW'(limit_reg);

    bbfp_seq #(
        .AW           (AW),
        .PW           (PW),
        .LW           (LW)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .value         (value),
        .count         (count),
        .little_endian (little_endian),
        .read_index    (read_index),
        .limit         (limit_eff),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rd_data   (mem_rd_data)
    );

    bbfp_mem #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    bbfp_ostage u_ostage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ok        (ok),
        .read_data (read_data)
    );

endmodule
